### src/etl_pkg.sv
// ----------------------------------------------------------------------------
// Expression token lexer package
// Token kinds, character codes, the token word layout and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etl_pkg;

  // Token kinds as they appear on the result port.
  typedef enum logic [4:0] {
    KIND_PLUS   = 5'd0,
    KIND_MINUS  = 5'd1,
    KIND_MULT   = 5'd2,
    KIND_DIV    = 5'd3,
    KIND_NUM    = 5'd4,
    KIND_LPAREN = 5'd5,
    KIND_RPAREN = 5'd6,
    KIND_LBRACE = 5'd7,
    KIND_RBRACE = 5'd8,
    KIND_COMMA  = 5'd9,
    KIND_DOT    = 5'd10,
    KIND_SEMI   = 5'd11,
    KIND_SLASH  = 5'd12,
    KIND_NOT    = 5'd13,
    KIND_NOTEQ  = 5'd14,
    KIND_ASSIGN = 5'd15,
    KIND_EQ     = 5'd16,
    KIND_GT     = 5'd17,
    KIND_GE     = 5'd18,
    KIND_LT     = 5'd19,
    KIND_LE     = 5'd20
  } token_kind_e;

  // Operator held for one character while waiting for a possible '='.
  typedef enum logic [1:0] {
    OP_NOT    = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_GT     = 2'd2,
    OP_LT     = 2'd3
  } held_op_e;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Largest fraction digit count.
  localparam logic [4:0] FRAC_MAX = 5'd31;

  // One result word.
  typedef struct packed {
    token_kind_e kind;
    logic [31:0] mantissa;
    logic [4:0]  frac_digits;
    logic        num_overflow;
    logic        run_last;
  } token_t;

  // Builds a token word; the last-token flag is set later.
  function automatic token_t make_token(input token_kind_e kind, input logic [31:0] mant,
                                        input logic [4:0] frac, input logic ovf);
    token_t t;
    t.kind         = kind;
    t.mantissa     = mant;
    t.frac_digits  = frac;
    t.num_overflow = ovf;
    t.run_last     = 1'b0;
    return t;
  endfunction

  // Kind of a held operator, either on its own or merged with a following '='.
  function automatic token_kind_e held_kind(input held_op_e op, input logic merged);
    token_kind_e k;
    case (op)
      OP_NOT:    k = merged ? KIND_NOTEQ : KIND_NOT;
      OP_ASSIGN: k = merged ? KIND_EQ    : KIND_ASSIGN;
      OP_GT:     k = merged ? KIND_GE    : KIND_GT;
      OP_LT:     k = merged ? KIND_LE    : KIND_LT;
      default:   k = KIND_NOT;
    endcase
    return k;
  endfunction

endpackage

### src/expression_token_lexer_top.sv
// ----------------------------------------------------------------------------
// Expression token lexer
// Turns a stream of ASCII characters into operator, punctuation and number
// tokens, one character per word in and one token per word out.
// ----------------------------------------------------------------------------
// The lexer takes one character per cycle and returns zero to three tokens for
// it. A character that causes at most one token leaves the input stall low, so
// a steady stream of such characters moves at one word per cycle while the
// output is not stalled. When a character causes two or three tokens, the
// input stalls while they leave the three-entry result buffer one per cycle;
// that buffer, and how fast the downstream side drains it, set the rate. The
// characters '!', '=', '>' and '<' are held until the next character so a
// following '=' can merge into "!=", "==", ">=" or "<="; a single backslash is
// held the same way, and two backslashes open a comment that runs through the
// next newline. Numbers are returned as a saturating mantissa of all their
// digits plus a count of the digits after the point, so that the value equals
// the mantissa divided by ten to the power of that count. A word with
// text_end_i set flushes whatever is held and returns the lexer to its reset
// state. The run_last_o flag marks the last token caused by one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expression_token_lexer_top #(
  parameter int unsigned MANT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Character input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        text_end_i,
  // Token output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] mantissa_o,
  output logic [4:0]  frac_digits_o,
  output logic        num_overflow_o,
  output logic        run_last_o
);

  // Lexer modes: what is held from earlier characters.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_BS,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_CMT
  } mode_e;

  localparam int unsigned WideW = MANT_BITS + 4;

  // Lexer state.
  mode_e                   mode_q, mode_d;
  etl_pkg::held_op_e       op_q, op_d;
  logic [MANT_BITS-1:0]    val_q, val_d;
  logic [4:0]              frac_q, frac_d;
  logic                    ovf_q, ovf_d;

  // Result buffer: up to three tokens, the oldest in entry zero.
  etl_pkg::token_t         tok_q [3];
  etl_pkg::token_t         tok_d [3];
  logic [1:0]              cnt_q;
  logic [1:0]              n_d;

  logic                    in_accept;
  logic                    out_pop;
  logic                    is_digit;
  logic                    used;
  logic [3:0]              digit;
  logic [WideW-1:0]        acc_wide;
  logic [MANT_BITS-1:0]    acc_val;
  logic                    acc_sat;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  // A new character is taken when the buffer is empty by the end of this cycle.
  assign in_stall_o  = !((cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i));
  assign in_accept   = in_valid_i && !in_stall_o;

  assign token_kind_o   = tok_q[0].kind;
  assign mantissa_o     = tok_q[0].mantissa;
  assign frac_digits_o  = tok_q[0].frac_digits;
  assign num_overflow_o = tok_q[0].num_overflow;
  assign run_last_o     = tok_q[0].run_last;

  assign is_digit = char_code_i inside {[etl_pkg::CH_ZERO:etl_pkg::CH_NINE]};
  assign digit    = char_code_i[3:0];

  // Mantissa times ten plus the new digit, saturating when it no longer fits.
  assign acc_wide = ({4'b0000, val_q} << 3) + ({4'b0000, val_q} << 1) + WideW'(digit);
  assign acc_sat  = (acc_wide[WideW-1:MANT_BITS] != 4'b0000);
  assign acc_val  = acc_sat ? {MANT_BITS{1'b1}} : acc_wide[MANT_BITS-1:0];

  always_comb begin
    mode_d = mode_q;
    op_d   = op_q;
    val_d  = val_q;
    frac_d = frac_q;
    ovf_d  = ovf_q;
    n_d    = 2'd0;
    used   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tok_d[i] = '0;
    end

    // Resolve whatever the previous characters left pending.
    case (mode_q)
      MODE_OP: begin
        if (char_code_i == etl_pkg::CH_EQUAL) begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::held_kind(op_q, 1'b1), '0, '0, 1'b0);
          used = 1'b1;
        end else begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::held_kind(op_q, 1'b0), '0, '0, 1'b0);
        end
        n_d    = n_d + 2'd1;
        mode_d = MODE_IDLE;
      end
      MODE_BS: begin
        if (char_code_i == etl_pkg::CH_BSLASH) begin
          mode_d = MODE_CMT;
          used   = 1'b1;
        end else begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_SLASH, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
          mode_d     = MODE_IDLE;
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          val_d = acc_val;
          ovf_d = ovf_q | acc_sat;
          used  = 1'b1;
        end else if (char_code_i == etl_pkg::CH_POINT) begin
          mode_d = MODE_DOT;
          used   = 1'b1;
        end else begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_NUM, 32'(val_q), frac_q, ovf_q);
          n_d        = n_d + 2'd1;
          mode_d     = MODE_IDLE;
        end
      end
      MODE_DOT, MODE_FRAC: begin
        if (is_digit) begin
          if (frac_q == etl_pkg::FRAC_MAX) begin
            ovf_d = 1'b1;
          end else begin
            frac_d = frac_q + 5'd1;
            val_d  = acc_val;
            ovf_d  = ovf_q | acc_sat;
          end
          mode_d = MODE_FRAC;
          used   = 1'b1;
        end else begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_NUM, 32'(val_q), frac_q, ovf_q);
          n_d        = n_d + 2'd1;
          // A point with no digit after it becomes a dot token of its own.
          if (mode_q == MODE_DOT) begin
            tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_DOT, '0, '0, 1'b0);
            n_d        = n_d + 2'd1;
          end
          mode_d = MODE_IDLE;
        end
      end
      MODE_CMT: begin
        if (char_code_i == etl_pkg::CH_NEWLINE) begin
          mode_d = MODE_IDLE;
        end
        used = 1'b1;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    // The character starts fresh when nothing above consumed it.
    if (!used) begin
      mode_d = MODE_IDLE;
      case (char_code_i)
        etl_pkg::CH_PLUS: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_PLUS, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_MINUS: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_MINUS, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_STAR: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_MULT, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_SLASH: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_DIV, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_LPAREN: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_LPAREN, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_RPAREN: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_RPAREN, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_LBRACE: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_LBRACE, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_RBRACE: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_RBRACE, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_COMMA: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_COMMA, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_POINT: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_DOT, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_SEMI: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_SEMI, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        etl_pkg::CH_BSLASH: begin
          mode_d = MODE_BS;
        end
        etl_pkg::CH_BANG: begin
          mode_d = MODE_OP;
          op_d   = etl_pkg::OP_NOT;
        end
        etl_pkg::CH_EQUAL: begin
          mode_d = MODE_OP;
          op_d   = etl_pkg::OP_ASSIGN;
        end
        etl_pkg::CH_GREATER: begin
          mode_d = MODE_OP;
          op_d   = etl_pkg::OP_GT;
        end
        etl_pkg::CH_LESS: begin
          mode_d = MODE_OP;
          op_d   = etl_pkg::OP_LT;
        end
        default: begin
          // A first digit cannot overflow, so it is loaded as it is.
          if (is_digit) begin
            val_d  = MANT_BITS'(digit);
            frac_d = 5'd0;
            ovf_d  = 1'b0;
            mode_d = MODE_INT;
          end
        end
      endcase
    end

    // At the final character, flush what is held and return to reset state.
    if (text_end_i) begin
      case (mode_d)
        MODE_OP: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::held_kind(op_d, 1'b0), '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        MODE_BS: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_SLASH, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        MODE_INT, MODE_FRAC: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_NUM, 32'(val_d), frac_d, ovf_d);
          n_d        = n_d + 2'd1;
        end
        MODE_DOT: begin
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_NUM, 32'(val_d), frac_d, ovf_d);
          n_d        = n_d + 2'd1;
          tok_d[n_d] = etl_pkg::make_token(etl_pkg::KIND_DOT, '0, '0, 1'b0);
          n_d        = n_d + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d = MODE_IDLE;
      op_d   = etl_pkg::OP_NOT;
      val_d  = '0;
      frac_d = 5'd0;
      ovf_d  = 1'b0;
    end

    if (n_d != 2'd0) begin
      tok_d[n_d - 2'd1].run_last = 1'b1;
    end
  end

  // Lexer state and buffer fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      op_q   <= etl_pkg::OP_NOT;
      val_q  <= '0;
      frac_q <= 5'd0;
      ovf_q  <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (in_accept) begin
        mode_q <= mode_d;
        op_q   <= op_d;
        val_q  <= val_d;
        frac_q <= frac_d;
        ovf_q  <= ovf_d;
        cnt_q  <= n_d;
      end else if (out_pop) begin
        cnt_q  <= cnt_q - 2'd1;
      end
    end
  end

  // Token words; an accepted character always finds the buffer drained.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tok_q[0] <= tok_d[0];
      tok_q[1] <= tok_d[1];
      tok_q[2] <= tok_d[2];
    end else if (out_pop) begin
      tok_q[0] <= tok_q[1];
      tok_q[1] <= tok_q[2];
    end
  end

endmodule
